// File: sv/selu_activation_fwd_bwd_defines.svh
// Assertion macros for the SELU activation block
`ifndef SELU_ACTIVATION_FWD_BWD_DEFINES_SVH
`define SELU_ACTIVATION_FWD_BWD_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define SELU_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted
`define SELU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/selu_pkg.sv
// Shared widths, constants, item types and exponent table for the SELU block
`default_nettype none

package selu_pkg;

    // Number format of the data words
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 11;

    // Q2.30 constants: scale and scale*alpha (alpha = 1.6732632423543772)
    localparam int Q_BITS = 30;
    localparam int K_W    = 31;
    localparam logic [K_W-1:0] Q30_ONE         = K_W'(1) << Q_BITS;
    localparam logic [K_W-1:0] SCALE_Q30       = 31'd1128181595;
    localparam logic [K_W-1:0] SCALE_ALPHA_Q30 = 31'd1887744793;

    // Operand and product widths
    localparam int MAG_W    = DATA_WIDTH;
    localparam int UC_SHIFT = Q_BITS - FRAC_BITS;
    localparam int UC_W     = ((DATA_WIDTH + UC_SHIFT) > K_W) ? (DATA_WIDTH + UC_SHIFT) : K_W;
    localparam int OPA_W    = (MAG_W > K_W) ? MAG_W : K_W;
    localparam int PROD_A_W = OPA_W + K_W;
    localparam int PROD_B_W = MAG_W + UC_W;
    localparam int PROD_W   = ((PROD_A_W > PROD_B_W) ? PROD_A_W : PROD_B_W) + 1;
    localparam int NEG_SHIFT = 2 * Q_BITS - FRAC_BITS;
    localparam int RMAG_W   = PROD_W - Q_BITS;

    // Exponent chain: integer bits 1,2,4,8,16 then fraction bits down to 2^-FRAC_BITS, at most 2^-24
    localparam int N_INT  = 5;
    localparam int N_FRAC = (FRAC_BITS < 24) ? FRAC_BITS : 24;
    localparam int N_EXP  = N_INT + N_FRAC;

    // Stream payload widths
    localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    // Clamp values of the result word
    localparam logic [DATA_WIDTH-1:0] RES_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] RES_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation select on the input side
    localparam logic FUNC_FWD = 1'b0;
    localparam logic FUNC_BWD = 1'b1;

    // Item class decided in the front
    typedef enum logic [1:0] {
        K_FWD_POS,
        K_FWD_NEG,
        K_BWD_POS,
        K_BWD_NEG
    } t_kind;

    // Classified item handed from front to back
    typedef struct packed {
        t_kind             kind;
        logic              neg;   // sign of the final result
        logic              zexp;  // exponential underflows to zero
        logic [MAG_W-1:0]  ma;    // |x| forward, |grad| backward
        logic [UC_W-1:0]   mb;    // |y*2^(30-F) + scale*alpha|, backward negative
    } t_item;

    // Queue status seen by the top level
    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_qstat;

    // exp(-2^k) in Q2.30: index 0..4 integer weights, 5.. fraction weights
    function automatic logic [K_W-1:0] exp_tab(input int idx);
        logic [K_W-1:0] v;
        unique case (idx)
            0:  v = 31'd395007542;
            1:  v = 31'd145315154;
            2:  v = 31'd19666267;
            3:  v = 31'd360200;
            4:  v = 31'd121;
            5:  v = 31'd651257337;
            6:  v = 31'd836230973;
            7:  v = 31'd947573834;
            8:  v = 31'd1008687095;
            9:  v = 31'd1040706261;
            10: v = 31'd1057094900;
            11: v = 31'd1065385899;
            12: v = 31'd1069555701;
            13: v = 31'd1071646719;
            14: v = 31'd1072693760;
            15: v = 31'd1073217664;
            16: v = 31'd1073479712;
            17: v = 31'd1073610760;
            18: v = 31'd1073676290;
            19: v = 31'd1073709056;
            20: v = 31'd1073725440;
            21: v = 31'd1073733632;
            22: v = 31'd1073737728;
            23: v = 31'd1073739776;
            24: v = 31'd1073740800;
            25: v = 31'd1073741312;
            26: v = 31'd1073741568;
            27: v = 31'd1073741696;
            28: v = 31'd1073741760;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: sv/selu_front.sv
// Front stage: takes an input item, classifies it and forms its operands
`default_nettype none

module selu_front
    import selu_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_func,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    input  logic signed [DATA_WIDTH-1:0] i_grad,
    output logic                         o_ready,
    input  logic                         i_space,  // queue can take a transfer
    output logic                         o_valid,
    output t_item                        o_item
);

    logic              r_valid;
    t_item             r_item;
    t_item             n_item;
    logic              w_vneg;
    logic              w_gneg;
    logic [MAG_W-1:0]  w_vmag;
    logic [MAG_W-1:0]  w_gmag;
    logic [UC_W-1:0]   w_sh;
    logic [UC_W-1:0]   w_sa;
    logic              w_cneg;
    logic [UC_W-1:0]   w_uc;
    logic              w_zexp;

    // Magnitudes of the two data words
    assign w_vneg = i_value[DATA_WIDTH-1];
    assign w_gneg = i_grad[DATA_WIDTH-1];
    assign w_vmag = w_vneg ? MAG_W'(-i_value) : MAG_W'(i_value);
    assign w_gmag = w_gneg ? MAG_W'(-i_grad) : MAG_W'(i_grad);

    // c = y*2^(30-F) + scale*alpha with y < 0, so c = SA - |y|*2^(30-F)
    assign w_sh   = UC_W'(w_vmag) << UC_SHIFT;
    assign w_sa   = UC_W'(SCALE_ALPHA_Q30);
    assign w_cneg = w_sh > w_sa;
    assign w_uc   = w_cneg ? (w_sh - w_sa) : (w_sa - w_sh);

    // Integer part of 32 or more sends the exponential to zero
    assign w_zexp = (64'(w_vmag) >> FRAC_BITS) >= 64'd32;

    // Classification
    always_comb begin
        n_item      = '0;
        n_item.zexp = w_zexp;
        n_item.mb   = w_uc;
        if (i_func == FUNC_FWD) begin
            n_item.ma   = w_vmag;
            n_item.kind = w_vneg ? K_FWD_NEG : K_FWD_POS;
            n_item.neg  = w_vneg;
        end else begin
            n_item.ma   = w_gmag;
            n_item.kind = w_vneg ? K_BWD_NEG : K_BWD_POS;
            n_item.neg  = w_vneg ? (w_gneg ^ w_cneg) : w_gneg;
        end
    end

    assign o_ready = !r_valid || i_space;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Holding register toward the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// File: sv/selu_queue.sv
// Short register queue decoupling the front from the back pipeline
`default_nettype none

module selu_queue
    import selu_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    input  logic   i_pop,
    output t_item  o_item,
    output t_qstat o_stat
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] n_rd;

    // Pointer wrap
    assign n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;

    assign o_item       = r_mem[r_rd];
    assign o_stat.count = r_cnt;
    assign o_stat.full  = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_stat.empty = r_cnt == '0;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: sv/selu_back.sv
// Back pipeline: exponential chain, final multiply, rounding and saturation
`default_nettype none

module selu_back
    import selu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,   // queue holds an item
    input  t_item                 i_item,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_result,
    output logic                  o_saturated,
    input  logic                  i_ready
);

    localparam logic [PROD_W-1:0] HALF_SHORT = PROD_W'(1) << (Q_BITS - 1);
    localparam logic [PROD_W-1:0] HALF_LONG  = PROD_W'(1) << (NEG_SHIFT - 1);
    localparam logic [RMAG_W-1:0] LIM_POS    = RMAG_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    localparam logic [RMAG_W-1:0] LIM_NEG    = RMAG_W'(64'd1 << (DATA_WIDTH - 1));

    // Product of two Q2.30 values rounded half up back to Q2.30
    function automatic logic [K_W-1:0] round_q30(input logic [K_W-1:0] a,
                                                 input logic [K_W-1:0] b);
        logic [2*K_W:0] p;
        p = (2*K_W+1)'(a) * (2*K_W+1)'(b) + ((2*K_W+1)'(1) << (Q_BITS - 1));
        return K_W'(p >> Q_BITS);
    endfunction

    logic                  w_adv;
    logic                  r_ev [N_EXP];
    t_item                 r_ei [N_EXP];
    logic [K_W-1:0]        r_er [N_EXP];

    logic                  r_mv;
    logic                  r_mneg;
    logic                  r_mlong;
    logic [PROD_W-1:0]     r_mprod;
    logic                  r_rv;
    logic                  r_rneg;
    logic [RMAG_W-1:0]     r_rmag;
    logic                  r_ov;
    logic [DATA_WIDTH-1:0] r_ores;
    logic                  r_osat;

    t_item                 w_last;
    logic [K_W-1:0]        w_d;
    logic [OPA_W-1:0]      w_opa;
    logic [K_W-1:0]        w_opk;
    logic [PROD_A_W-1:0]   w_prod_a;
    logic [PROD_B_W-1:0]   w_prod_b;
    logic [PROD_W-1:0]     n_mprod;
    logic [PROD_W-1:0]     w_sum;
    logic [RMAG_W-1:0]     n_rmag;
    logic [RMAG_W-1:0]     w_lim;
    logic                  n_osat;
    logic [DATA_WIDTH-1:0] w_negmag;
    logic [DATA_WIDTH-1:0] n_ores;

    // Whole pipeline moves when the output slot is free or being taken
    assign w_adv = !r_ov || i_ready;
    assign o_pop = w_adv && i_valid;

    // Exponential chain: one table multiply per stage
    for (genvar k = 0; k < N_EXP; k++) begin : g_exp
        localparam int BIT_POS = (k < N_INT) ? FRAC_BITS + k : FRAC_BITS - (k - N_INT + 1);
        localparam logic [K_W-1:0] TAB = exp_tab(k);
        logic           w_v;
        t_item          w_item;
        logic [K_W-1:0] w_r;
        logic           w_bit;
        logic [K_W-1:0] n_r;

        if (k == 0) begin : g_head
            assign w_v    = i_valid;
            assign w_item = i_item;
            assign w_r    = i_item.zexp ? '0 : Q30_ONE;
        end else begin : g_tail
            assign w_v    = r_ev[k-1];
            assign w_item = r_ei[k-1];
            assign w_r    = r_er[k-1];
        end

        if (BIT_POS < MAG_W) begin : g_bit
            assign w_bit = w_item.ma[BIT_POS];
        end else begin : g_nobit
            assign w_bit = 1'b0;
        end

        assign n_r = (w_item.kind == K_FWD_NEG && w_bit) ? round_q30(w_r, TAB) : w_r;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ev[k] <= 1'b0;
            end else if (w_adv) begin
                r_ev[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_ei[k] <= w_item;
                r_er[k] <= n_r;
            end
        end
    end

    // Final multiply: constant path or grad times shifted-offset value
    assign w_last   = r_ei[N_EXP-1];
    assign w_d      = Q30_ONE - r_er[N_EXP-1];
    assign w_opa    = (w_last.kind == K_FWD_NEG) ? OPA_W'(w_d) : OPA_W'(w_last.ma);
    assign w_opk    = (w_last.kind == K_FWD_NEG) ? SCALE_ALPHA_Q30 : SCALE_Q30;
    assign w_prod_a = PROD_A_W'(w_opa) * PROD_A_W'(w_opk);
    assign w_prod_b = PROD_B_W'(w_last.ma) * PROD_B_W'(w_last.mb);
    assign n_mprod  = (w_last.kind == K_BWD_NEG) ? PROD_W'(w_prod_b) : PROD_W'(w_prod_a);

    // Round half up and drop the fraction
    assign w_sum  = r_mprod + (r_mlong ? HALF_LONG : HALF_SHORT);
    assign n_rmag = r_mlong ? RMAG_W'(w_sum >> NEG_SHIFT) : RMAG_W'(w_sum >> Q_BITS);

    // Clamp to the signed range and apply the sign
    assign w_lim    = r_rneg ? LIM_NEG : LIM_POS;
    assign n_osat   = r_rmag > w_lim;
    assign w_negmag = (~r_rmag[DATA_WIDTH-1:0]) + 1'b1;
    assign n_ores   = n_osat ? (r_rneg ? RES_MIN : RES_MAX)
                             : (r_rneg ? w_negmag : r_rmag[DATA_WIDTH-1:0]);

    // Valid bits of the tail stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            r_rv <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_mv <= r_ev[N_EXP-1];
            r_rv <= r_mv;
            r_ov <= r_rv;
        end
    end

    // Payload of the tail stages
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mprod <= n_mprod;
            r_mneg  <= w_last.neg;
            r_mlong <= w_last.kind == K_FWD_NEG;
            r_rmag  <= n_rmag;
            r_rneg  <= r_mneg;
            r_ores  <= n_ores;
            r_osat  <= n_osat;
        end
    end

    assign o_valid     = r_ov;
    assign o_result    = r_ores;
    assign o_saturated = r_osat;

endmodule

`default_nettype wire

// File: sv/selu_activation_fwd_bwd.sv
// Top level of the SELU activation block, forward and backward
//
//  channel   dir  payload                                  transfer when
//  s_axis    in   tdata: value, grad   tuser: func         tvalid && tready
//  m_axis    out  tdata: result        tuser: saturated    tvalid && tready
//
// One item per cycle sustained while m_axis does not stall; data words are Q4.11.
// Path: front register, queue, exponential chain (one Q2.30 table multiply per stage), back tail.
// Reset (i_rst_n low at a clock edge) clears valid bits, queue pointers and fill count only.
// A stalled m_axis freezes the back pipeline; the four-entry queue and the
// front register keep s_axis taking transfers until they fill.
`default_nettype none
`include "selu_activation_fwd_bwd_defines.svh"

module selu_activation_fwd_bwd
    import selu_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // value, grad
    input  logic                   s_axis_tuser,   // func
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // result
    output logic                   m_axis_tuser    // saturated
);

    logic                  w_f_valid;
    t_item                 w_f_item;
    logic                  w_q_push;
    logic                  w_q_pop;
    t_item                 w_q_item;
    t_qstat                w_q_stat;
    logic [DATA_WIDTH-1:0] w_result;

    assign w_q_push = w_f_valid && !w_q_stat.full;

    // Classification front
    selu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_func  (s_axis_tuser),
        .i_value (s_axis_tdata[DATA_WIDTH-1:0]),
        .i_grad  (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .o_ready (s_axis_tready),
        .i_space (!w_q_stat.full),
        .o_valid (w_f_valid),
        .o_item  (w_f_item)
    );

    // Decoupling queue
    selu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_f_item),
        .i_pop   (w_q_pop),
        .o_item  (w_q_item),
        .o_stat  (w_q_stat)
    );

    // Arithmetic back end
    selu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!w_q_stat.empty),
        .i_item      (w_q_item),
        .o_pop       (w_q_pop),
        .o_valid     (m_axis_tvalid),
        .o_result    (w_result),
        .o_saturated (m_axis_tuser),
        .i_ready     (m_axis_tready)
    );

    assign m_axis_tdata = OUT_TDATA_W'(w_result);

    // A clamped result is always one of the two range limits
    `SELU_ASSERT(a_sat_limit, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata[DATA_WIDTH-1:0] == RES_MAX || m_axis_tdata[DATA_WIDTH-1:0] == RES_MIN,
        "saturated result is not a range limit")

    // The back never pops an empty queue
    `SELU_ASSERT(a_pop_nonempty, i_clk, i_rst_n, w_q_pop, !w_q_stat.empty,
        "queue popped while empty")

    // Fill count follows a lone push
    `SELU_ASSERT_NXT(a_cnt_push, i_clk, i_rst_n, w_q_push && !w_q_pop,
        w_q_stat.count == QCNT_W'($past(w_q_stat.count) + 1'b1),
        "queue count did not rise on push")

endmodule

`default_nettype wire

// File: test/tb_selu_activation_fwd_bwd.sv
// Self-checking testbench for the SELU activation block, forward and backward
`timescale 1ns / 1ps

module tb_selu_activation_fwd_bwd;
    import selu_pkg::*;

    // Run length and guard limits
    localparam int  N_RANDOM    = 1150;
    localparam int  DRAIN_CYC   = 60;
    localparam int  CYCLE_LIMIT = 400000;

    // Q2.30 constants of the activation
    localparam logic [63:0] K_ONE         = 64'd1 << 30;
    localparam logic [63:0] K_SCALE       = 64'd1128181595;
    localparam logic [63:0] K_SCALE_ALPHA = 64'd1887744793;
    localparam int          NEG_SH        = 60 - FRAC_BITS;

    // exp(-1), exp(-2), exp(-4), exp(-8), exp(-16) in Q2.30
    localparam logic [63:0] EXP_INT_Q30 [0:4] = '{
        64'd395007542, 64'd145315154, 64'd19666267, 64'd360200, 64'd121
    };

    // exp(-2^-i), i = 1..24, in Q2.30
    localparam logic [63:0] EXP_FRAC_Q30 [0:23] = '{
        64'd651257337,  64'd836230973,  64'd947573834,  64'd1008687095,
        64'd1040706261, 64'd1057094900, 64'd1065385899, 64'd1069555701,
        64'd1071646719, 64'd1072693760, 64'd1073217664, 64'd1073479712,
        64'd1073610760, 64'd1073676290, 64'd1073709056, 64'd1073725440,
        64'd1073733632, 64'd1073737728, 64'd1073739776, 64'd1073740800,
        64'd1073741312, 64'd1073741568, 64'd1073741696, 64'd1073741760
    };

    // One directed stimulus row; typed rows carry their own result
    typedef struct packed {
        logic                  func;
        logic [DATA_WIDTH-1:0] value;
        logic [DATA_WIDTH-1:0] grad;
        logic                  typed;
        logic [DATA_WIDTH-1:0] res;
        logic                  sat;
    } t_row;

    // Expected output transfer
    typedef struct packed {
        logic [DATA_WIDTH-1:0] res;
        logic                  sat;
    } t_out;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // value, grad
    logic                   s_axis_tuser;   // func
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // result
    logic                   m_axis_tuser;   // saturated

    // Sideband that travels with the driven item
    logic                   drv_typed;
    logic [DATA_WIDTH-1:0]  drv_res;
    logic                   drv_sat;

    t_out                   pending_results[$];
    t_row                   dir_rows[$];
    int                     err_count;
    int                     cycle_count;
    int                     burst_left;

    selu_activation_fwd_bwd u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock, 10 ns period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Run guard
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_selu_activation_fwd_bwd NOT OK");
            $finish;
        end
    end

    function automatic logic [63:0] round_q30(input logic [63:0] p);
        return (p + (64'd1 << 29)) >> 30;
    endfunction

    // exp(-m) in Q2.30 as a product of table weights, m with FRAC_BITS fraction bits
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] m);
        logic [63:0] n;
        logic [63:0] r;
        n = m >> FRAC_BITS;
        r = K_ONE;
        if (n >= 64'd32)
            return 64'd0;
        for (int k = 0; k < 5; k++)
            if (n[k])
                r = round_q30(r * EXP_INT_Q30[k]);
        for (int k = 1; k <= FRAC_BITS; k++)
            if (k <= 24 && m[FRAC_BITS-k])
                r = round_q30(r * EXP_FRAC_Q30[k-1]);
        return r;
    endfunction

    // Clamp a signed magnitude to the word range
    function automatic t_out clamp_word(input logic neg, input logic [63:0] mag);
        logic [63:0] lim;
        t_out        o;
        lim   = (64'd1 << (DATA_WIDTH - 1)) - (neg ? 64'd0 : 64'd1);
        o.sat = (mag > lim);
        if (o.sat)
            mag = lim;
        o.res = neg ? DATA_WIDTH'(64'd0 - mag) : DATA_WIDTH'(mag);
        return o;
    endfunction

    // SELU forward value or backward gradient for one item
    function automatic t_out selu_expect(input logic func,
                                         input logic [DATA_WIDTH-1:0] value,
                                         input logic [DATA_WIDTH-1:0] grad);
        longint      v;
        longint      g;
        longint      c;
        logic [63:0] ug;
        logic [63:0] uc;
        logic [63:0] d;
        logic [63:0] mag;
        logic        neg;
        v = longint'($signed(value));
        if (func == FUNC_FWD) begin
            if (v >= 0) begin
                neg = 1'b0;
                mag = round_q30(64'(v) * K_SCALE);
            end else begin
                neg = 1'b1;
                d   = K_ONE - exp_neg_q30(64'(-v));
                mag = (d * K_SCALE_ALPHA + (64'd1 << (NEG_SH - 1))) >> NEG_SH;
            end
        end else begin
            g  = longint'($signed(grad));
            ug = (g < 0) ? 64'(-g) : 64'(g);
            if (v >= 0) begin
                neg = (g < 0);
                mag = round_q30(ug * K_SCALE);
            end else begin
                // y + scale*alpha, y lifted to Q2.30
                c  = v * (longint'(1) << (30 - FRAC_BITS)) + longint'(K_SCALE_ALPHA);
                uc = (c < 0) ? 64'(-c) : 64'(c);
                if (ug == 64'd0 || uc == 64'd0)
                    mag = 64'd0;
                else if (uc > (64'hFFFF_FFFF_FFFF_FFFF - (64'd1 << 29)) / ug)
                    mag = 64'hFFFF_FFFF_FFFF_FFFF;
                else
                    mag = round_q30(ug * uc);
                neg = (g < 0) != (c < 0);
            end
        end
        return clamp_word(neg, mag);
    endfunction

    // Random operand: full range, small, extremes, near the backward sign change
    function automatic logic [DATA_WIDTH-1:0] pick_operand();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3: return DATA_WIDTH'($urandom);
            4, 5:       return DATA_WIDTH'($urandom_range(0, 8191) - 4096);
            6: begin
                case ($urandom_range(0, 4))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    3:       return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
            7:          return DATA_WIDTH'($urandom_range(0, 7) - 3604);
            default:    return DATA_WIDTH'(-$urandom_range(1, 32768));
        endcase
    endfunction

    // Input and output monitors: predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        t_out e;
        t_out got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (drv_typed) begin
                    e.res = drv_res;
                    e.sat = drv_sat;
                end else begin
                    e = selu_expect(s_axis_tuser, s_axis_tdata[DATA_WIDTH-1:0],
                                    s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
                end
                pending_results.push_back(e);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.res = m_axis_tdata[DATA_WIDTH-1:0];
                got.sat = m_axis_tuser;
                if (pending_results.size() == 0) begin
                    $error("unexpected output transfer: result %0d saturated %0b",
                           $signed(got.res), got.sat);
                    err_count++;
                end else begin
                    e = pending_results.pop_front();
                    if (got.res !== e.res) begin
                        $error("result: expected %0d, actual %0d",
                               $signed(e.res), $signed(got.res));
                        err_count++;
                    end
                    if (got.sat !== e.sat) begin
                        $error("saturated: expected %0b, actual %0b", e.sat, got.sat);
                        err_count++;
                    end
                end
            end
        end
    end

    // Receiver stalls: always ready, random, periodic mask, or a solid stall
    initial begin
        int       mode;
        int       len;
        logic [7:0] mask;
        m_axis_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            len  = (mode == 3) ? $urandom_range(1, 30) : $urandom_range(10, 120);
            mask = 8'($urandom);
            for (int i = 0; i < len; i++) begin
                @(negedge i_clk);
                case (mode)
                    0:       m_axis_tready = 1'b1;
                    1:       m_axis_tready = 1'($urandom_range(0, 1));
                    2:       m_axis_tready = mask[i % 8] | (mask == 8'h00);
                    default: m_axis_tready = 1'b0;
                endcase
            end
        end
    end

    // Drive one item in bursts with random gaps; returns after its transfer
    task automatic send_item(input logic func, input logic [DATA_WIDTH-1:0] value,
                             input logic [DATA_WIDTH-1:0] grad, input logic typed,
                             input logic [DATA_WIDTH-1:0] res, input logic sat);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {grad, value};
        s_axis_tuser  = func;
        drv_typed     = typed;
        drv_res       = res;
        drv_sat       = sat;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Main sequence
    initial begin
        t_row      row;
        logic      f;
        logic [DATA_WIDTH-1:0] gv;
        err_count     = 0;
        burst_left    = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_FWD;
        drv_typed     = 1'b0;
        drv_res       = '0;
        drv_sat       = 1'b0;

        // Directed rows: func, value, grad, typed, result, saturated
        dir_rows.push_back('{FUNC_FWD, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0});
        dir_rows.push_back('{FUNC_FWD, 16'h0000, 16'hFFFF, 1'b1, 16'h0000, 1'b0});
        dir_rows.push_back('{FUNC_FWD, 16'h0001, 16'h0000, 1'b1, 16'h0001, 1'b0});
        dir_rows.push_back('{FUNC_FWD, 16'h7FFF, 16'h1234, 1'b1, 16'h7FFF, 1'b1});
        dir_rows.push_back('{FUNC_FWD, 16'h0800, 16'h0000, 1'b0, 16'h0000, 1'b0});
        dir_rows.push_back('{FUNC_FWD, 16'hFFFF, 16'h0000, 1'b0, 16'h0000, 1'b0});
        dir_rows.push_back('{FUNC_FWD, 16'hF800, 16'h0000, 1'b0, 16'h0000, 1'b0});
        dir_rows.push_back('{FUNC_FWD, 16'h8000, 16'h7FFF, 1'b0, 16'h0000, 1'b0});
        dir_rows.push_back('{FUNC_FWD, 16'h5555, 16'hAAAA, 1'b0, 16'h0000, 1'b0});
        dir_rows.push_back('{FUNC_FWD, 16'hAAAA, 16'h5555, 1'b0, 16'h0000, 1'b0});
        dir_rows.push_back('{FUNC_BWD, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0});
        dir_rows.push_back('{FUNC_BWD, 16'h0000, 16'h7FFF, 1'b1, 16'h7FFF, 1'b1});
        dir_rows.push_back('{FUNC_BWD, 16'h0000, 16'h8000, 1'b1, 16'h8000, 1'b1});
        dir_rows.push_back('{FUNC_BWD, 16'h8000, 16'h0000, 1'b1, 16'h0000, 1'b0});
        dir_rows.push_back('{FUNC_BWD, 16'h7FFF, 16'h8000, 1'b1, 16'h8000, 1'b1});
        dir_rows.push_back('{FUNC_BWD, 16'h8000, 16'h7FFF, 1'b0, 16'h0000, 1'b0});
        dir_rows.push_back('{FUNC_BWD, 16'h8000, 16'h8000, 1'b0, 16'h0000, 1'b0});
        dir_rows.push_back('{FUNC_BWD, 16'hFFFF, 16'h0001, 1'b0, 16'h0000, 1'b0});
        // sign change of y + scale*alpha sits between y = -3601 and y = -3600
        dir_rows.push_back('{FUNC_BWD, 16'hF1F0, 16'h0800, 1'b0, 16'h0000, 1'b0});
        dir_rows.push_back('{FUNC_BWD, 16'hF1EF, 16'h0800, 1'b0, 16'h0000, 1'b0});
        dir_rows.push_back('{FUNC_BWD, 16'hF800, 16'hAAAA, 1'b0, 16'h0000, 1'b0});
        dir_rows.push_back('{FUNC_BWD, 16'h1000, 16'h5555, 1'b0, 16'h0000, 1'b0});

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_item(row.func, row.value, row.grad, row.typed, row.res, row.sat);
        end

        // Random items
        for (int i = 0; i < N_RANDOM; i++) begin
            f  = ($urandom_range(0, 1) == 0) ? FUNC_FWD : FUNC_BWD;
            gv = ($urandom_range(0, 7) == 0) ? pick_operand() : DATA_WIDTH'($urandom);
            send_item(f, pick_operand(), gv, 1'b0, '0, 1'b0);
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        drv_typed     = 1'b0;

        // Drain, then watch for stray transfers
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (err_count == 0 && pending_results.size() == 0)
            $display("tb_selu_activation_fwd_bwd OK");
        else
            $display("tb_selu_activation_fwd_bwd NOT OK");
        $finish;
    end

endmodule
